/* sv/dq_pkg.sv */
`default_nettype none

package dq_pkg;

  localparam int unsigned DQ_DEPTH = 64;

  localparam int unsigned DATA_W = 17;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned KIND_W = 3;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

  localparam logic [KIND_W-1:0] KIND_POPPED     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LISTED     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DUMP_EMPTY = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_EMPTY  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PUSH_FULL  = 3'd4;

endpackage

`default_nettype wire

/* sv/dq_if.sv */
`default_nettype none

interface dq_cmd_if import dq_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [DATA_W-1:0] data_value;

  modport source (output valid, output command, output data_value, input ready);
  modport sink   (input valid, input command, input data_value, output ready);
endinterface

interface dq_res_if import dq_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result_value;
  logic [KIND_W-1:0] result_kind;
  logic              last_of_run;

  modport source (output valid, output result_value, output result_kind,
                  output last_of_run, input ready);
  modport sink   (input valid, input result_value, input result_kind,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

/* sv/dq_ram.sv */
`default_nettype none

module dq_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/double_ended_queue.sv */
// Double-ended queue of DEPTH values of 17 bits held in one ring RAM with a
// single write and a single registered read port. Each command word asks for
// push front, push back, pop front, pop back or a dump of the whole queue from
// front to back. A push returns nothing unless the queue is full; a pop
// returns the removed value; a dump returns one listed word per cycle for each
// stored value while the result side takes every word, the final one marked by
// last_of_run, and holds the block until its last word is issued, since the
// one RAM read port reads one element at a time. Errors (push when full, pop when
// empty, dump when empty) return a single word with value zero. Unused command
// codes are taken and dropped. The RAM read register doubles as the value
// field of the output register, so a command is taken whenever the block is
// not dumping and the output word is empty or being taken in the same cycle;
// a stall on the result side stalls the command side.
`default_nettype none

module double_ended_queue import dq_pkg::*; #(
  parameter int unsigned DEPTH = DQ_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dq_cmd_if.sink    cmd_i,
  dq_res_if.source  res_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = $clog2(2 * DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic              state_q, state_d;
  logic [AW-1:0]     front_q, front_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     cur_q, cur_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic              last_q, last_d;
  logic              zero_q, zero_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              slot_free, accept, full, empty;
  logic [AW-1:0]     front_dec, front_inc, cur_inc, back_wr, back_rd;

  function automatic logic [AW-1:0] wrap_sum(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
    return r[AW-1:0];
  endfunction

  assign slot_free   = !out_valid_q || res_o.ready;
  assign cmd_i.ready = (state_q == ST_IDLE) && slot_free;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign full        = (count_q == CW'(DEPTH));
  assign empty       = (count_q == '0);

  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
  assign front_inc = wrap_sum(SW'(front_q) + SW'(1));
  assign cur_inc   = wrap_sum(SW'(cur_q) + SW'(1));
  assign back_wr   = wrap_sum(SW'(front_q) + SW'(count_q));
  assign back_rd   = wrap_sum(SW'(front_q) + SW'(count_q) - SW'(1));

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    count_d     = count_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    last_d      = last_q;
    zero_d      = zero_q;
    ram_we      = 1'b0;
    ram_waddr   = back_wr;
    ram_re      = 1'b0;
    ram_raddr   = front_q;

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_i.command) inside
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              if (full) begin
                out_valid_d = 1'b1;
                kind_d      = KIND_PUSH_FULL;
                last_d      = 1'b1;
                zero_d      = 1'b1;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CW'(1);
                if (cmd_i.command == CMD_PUSH_FRONT) begin
                  ram_waddr = front_dec;
                  front_d   = front_dec;
                end
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              out_valid_d = 1'b1;
              last_d      = 1'b1;
              if (empty) begin
                kind_d = KIND_POP_EMPTY;
                zero_d = 1'b1;
              end else begin
                kind_d  = KIND_POPPED;
                zero_d  = 1'b0;
                ram_re  = 1'b1;
                count_d = count_q - CW'(1);
                if (cmd_i.command == CMD_POP_FRONT) begin
                  front_d = front_inc;
                end else begin
                  ram_raddr = back_rd;
                end
              end
            end
            CMD_DUMP: begin
              out_valid_d = 1'b1;
              if (empty) begin
                kind_d = KIND_DUMP_EMPTY;
                last_d = 1'b1;
                zero_d = 1'b1;
              end else begin
                kind_d = KIND_LISTED;
                zero_d = 1'b0;
                ram_re = 1'b1;
                last_d = (count_q == CW'(1));
                if (count_q != CW'(1)) begin
                  state_d = ST_DUMP;
                  cur_d   = front_inc;
                  idx_d   = CW'(1);
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_DUMP: begin
        // advance one element each time the output word frees up
        if (slot_free) begin
          ram_re      = 1'b1;
          ram_raddr   = cur_q;
          out_valid_d = 1'b1;
          kind_d      = KIND_LISTED;
          zero_d      = 1'b0;
          last_d      = (idx_q == count_q - CW'(1));
          cur_d       = cur_inc;
          idx_d       = idx_q + CW'(1);
          if (idx_q == count_q - CW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= '0;
      count_q     <= '0;
      cur_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      count_q     <= count_d;
      cur_q       <= cur_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    last_q <= last_d;
    zero_q <= zero_d;
  end

  dq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd_i.data_value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign res_o.valid        = out_valid_q;
  assign res_o.result_value = zero_q ? '0 : ram_rdata;
  assign res_o.result_kind  = kind_q;
  assign res_o.last_of_run  = last_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("element count beyond depth");

  a_front_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q <= AW'(DEPTH - 1))
    else $error("front index beyond depth");

  a_dump_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |=> ($stable(count_q) && $stable(front_q)))
    else $error("queue changed during dump");

  a_dump_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DUMP) |-> (idx_q < count_q && idx_q != '0))
    else $error("dump index out of run");

  a_open_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !last_q) |-> (state_q == ST_DUMP))
    else $error("unfinished run outside dump");
`endif

endmodule

`default_nettype wire

/* tb/double_ended_queue_tb.sv */
`timescale 1ns / 100ps

module double_ended_queue_tb;
  import dq_pkg::*;

  localparam int IDX_W = $clog2(DQ_DEPTH);
  localparam int CNT_W = $clog2(DQ_DEPTH + 1);
  localparam int unsigned VALUE_TOP = 99999;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = DQ_DEPTH + 8;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [KIND_W-1:0] kind;
    logic              last;
  } dq_result_t;

  logic clk;
  logic rst_n;

  dq_cmd_if cmd_if ();
  dq_res_if res_if ();

  double_ended_queue dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  // shadow of the ring store and its pointers
  logic [DATA_W-1:0] deque_mem [DQ_DEPTH];
  logic [IDX_W-1:0]  head_pos;
  logic [CNT_W-1:0]  fill_level;
  dq_result_t        pending_results [$];

  int src_idle_pct;
  int snk_stall_pct;
  int error_count;
  int cycle_count;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void expect_result(input logic [DATA_W-1:0] value,
                                        input logic [KIND_W-1:0] kind,
                                        input logic last);
    dq_result_t r;
    r.value = value;
    r.kind  = kind;
    r.last  = last;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_deque(input logic [CMD_W-1:0] cmd,
                                        input logic [DATA_W-1:0] val);
    logic [IDX_W-1:0] pos;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (fill_level >= CNT_W'(DQ_DEPTH)) begin
          expect_result('0, KIND_PUSH_FULL, 1'b1);
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            head_pos = IDX_W'((int'(head_pos) + DQ_DEPTH - 1) % DQ_DEPTH);
            deque_mem[head_pos] = val;
          end else begin
            pos = IDX_W'((int'(head_pos) + int'(fill_level)) % DQ_DEPTH);
            deque_mem[pos] = val;
          end
          fill_level++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (fill_level == '0) begin
          expect_result('0, KIND_POP_EMPTY, 1'b1);
        end else begin
          if (cmd == CMD_POP_FRONT) begin
            pos = head_pos;
            head_pos = IDX_W'((int'(head_pos) + 1) % DQ_DEPTH);
          end else begin
            pos = IDX_W'((int'(head_pos) + int'(fill_level) - 1) % DQ_DEPTH);
          end
          fill_level--;
          expect_result(deque_mem[pos], KIND_POPPED, 1'b1);
        end
      end
      CMD_DUMP: begin
        if (fill_level == '0) begin
          expect_result('0, KIND_DUMP_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < int'(fill_level); i++) begin
            pos = IDX_W'((int'(head_pos) + i) % DQ_DEPTH);
            expect_result(deque_mem[pos], KIND_LISTED, i + 1 == int'(fill_level));
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    if ($urandom_range(99) < 85) begin
      return DATA_W'($urandom_range(1, VALUE_TOP));
    end
    return DATA_W'($urandom_range(0, (1 << DATA_W) - 1));
  endfunction

  // offer one command word, idling first at the current sender rate
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= cmd;
    cmd_if.data_value <= val;
    do @(posedge clk); while (cmd_if.ready !== 1'b1);
    predict_deque(cmd, val);
  endtask

  // drop valid and hold until every expected word has come back
  task automatic hold_sender();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_errors();
    send_word(CMD_POP_FRONT, rand_value());
    send_word(CMD_POP_BACK, rand_value());
    send_word(CMD_DUMP, rand_value());
  endtask

  task automatic test_value_extremes();
    send_word(CMD_PUSH_BACK, DATA_W'(1));
    send_word(CMD_PUSH_BACK, DATA_W'(VALUE_TOP));
    send_word(CMD_PUSH_FRONT, '0);
    send_word(CMD_PUSH_FRONT, '1);
    send_word(CMD_PUSH_BACK, DATA_W'(17'h0aaaa));
    send_word(CMD_PUSH_FRONT, DATA_W'(17'h15555));
    send_word(CMD_DUMP, '0);
  endtask

  // take from alternate ends until empty, then refill from each end alone
  task automatic test_end_order();
    repeat (3) begin
      send_word(CMD_POP_FRONT, rand_value());
      send_word(CMD_POP_BACK, rand_value());
    end
    send_word(CMD_PUSH_FRONT, rand_value());
    send_word(CMD_POP_BACK, rand_value());
    send_word(CMD_PUSH_BACK, rand_value());
    send_word(CMD_POP_FRONT, rand_value());
  endtask

  task automatic test_unused_codes();
    send_word(CMD_PUSH_BACK, rand_value());
    for (int c = CMD_DUMP + 1; c < (1 << CMD_W); c++) begin
      send_word(CMD_W'(c), rand_value());
    end
    send_word(CMD_POP_FRONT, rand_value());
  endtask

  task automatic test_random_traffic(input int items, input int push_pct, input int pop_pct);
    int r;
    logic [CMD_W-1:0] cmd;
    for (int n = 0; n < items; n++) begin
      r = $urandom_range(99);
      if (r < push_pct) begin
        cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
      end else if (r < push_pct + pop_pct) begin
        cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
      end else if (r < 97) begin
        cmd = CMD_DUMP;
      end else begin
        cmd = CMD_W'($urandom_range(CMD_DUMP + 1, (1 << CMD_W) - 1));
      end
      send_word(cmd, rand_value());
    end
  endtask

  function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                      input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(negedge clk) begin
    res_if.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin : result_check
    dq_result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word: expected none, got value %0d kind %0d last %0b",
                 $time, res_if.result_value, res_if.result_kind, res_if.last_of_run);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_value", want.value, res_if.result_value);
        check_field("result_kind", DATA_W'(want.kind), DATA_W'(res_if.result_kind));
        check_field("last_of_run", DATA_W'(want.last), DATA_W'(res_if.last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("double_ended_queue_tb: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    cmd_if.valid      = 1'b0;
    cmd_if.command    = CMD_PUSH_FRONT;
    cmd_if.data_value = '0;
    res_if.ready      = 1'b0;
    head_pos          = '0;
    fill_level        = '0;
    src_idle_pct      = 0;
    snk_stall_pct     = 0;
    error_count       = 0;
    cycle_count       = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_errors();
    test_value_extremes();
    test_end_order();
    test_unused_codes();
    hold_sender();

    // fill towards full or drain towards empty under each idling pattern, then churn in all but the last
    test_random_traffic(100, 75, 18);
    test_random_traffic(25, 45, 45);
    hold_sender();

    src_idle_pct = 53;
    test_random_traffic(100, 18, 75);
    test_random_traffic(25, 45, 45);
    hold_sender();

    src_idle_pct  = 0;
    snk_stall_pct = 53;
    test_random_traffic(100, 75, 18);
    test_random_traffic(25, 45, 45);
    hold_sender();

    src_idle_pct  = 38;
    snk_stall_pct = 38;
    test_random_traffic(125, 18, 75);
    hold_sender();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("double_ended_queue_tb: done, clean");
    end else begin
      $display("double_ended_queue_tb: done, errors");
    end
    $finish;
  end

endmodule
